/* rtl/cnco_pkg.sv */
// Shared constants, types and cosine table generation for the interpolated cosine oscillator.
`default_nettype none

package cnco_pkg;

   // Default build: 18 fraction bits, 512-step table
   localparam int FRAC_BITS_DEF = 18;
   localparam int TABLE_LOG_DEF = 9;

   // Fixed field widths
   localparam int FREQ_W   = 32;
   localparam int CSR_W    = 32;
   localparam int CSR_AW   = 3;

   // Register indexes
   localparam int unsigned REG_INCREMENT_PER_HZ = 0;

   // Input word actions
   localparam logic ACT_FREQUENCY = 1'b0;
   localparam logic ACT_SET_PHASE = 1'b1;

   // Two pi in Q31
   localparam longint unsigned TWO_PI_Q31 = 64'd13493037705;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_ACC,
      ST_LERP,
      ST_SUM
   } cnco_state_type;

   // Unsigned quotient by shift and subtract; used only when the table is built
   function automatic longint unsigned shift_sub_quotient(input longint unsigned num,
                                                          input longint unsigned den);
      longint unsigned quo;
      longint unsigned rem;
      quo = '0;
      rem = '0;
      for (int bit_pos = 63; bit_pos >= 0; bit_pos--) begin
         rem = {rem[62:0], num[bit_pos]};
         quo = quo << 1;
         if (rem >= den) begin
            rem = rem - den;
            quo = quo | 64'd1;
         end
      end
      return quo;
   endfunction

   // cos(2*pi*j/2^tl) in fb fraction bits, first quadrant, Taylor series in Q31
   function automatic longint quarter_cos(input int j, input int tl, input int fb);
      longint unsigned x;
      longint unsigned x2;
      longint unsigned term;
      longint unsigned dv;
      longint          sum;
      int              s;
      x    = (TWO_PI_Q31 * longint'(j) + (64'd1 << (tl - 1))) >> tl;
      x2   = (x * x) >> 31;
      term = 64'd1 << 31;
      sum  = longint'(term);
      s    = 31 - fb;
      for (int k = 1; k <= 15; k++) begin
         term = (term * x2) >> 31;
         dv   = longint'((2 * k - 1) * (2 * k));
         term = shift_sub_quotient(term, dv);
         if ((k & 1) != 0) begin
            sum = sum - longint'(term);
         end else begin
            sum = sum + longint'(term);
         end
      end
      if (sum < 0) begin
         sum = 0;
      end
      if (sum > (longint'(1) << 31)) begin
         sum = longint'(1) << 31;
      end
      return longint'((longint'(sum) + (longint'(1) << (s - 1))) >>> s);
   endfunction

   // Full-period table entry built from the first quadrant by symmetry
   function automatic longint cos_entry(input int i, input int tl, input int fb);
      int n;
      int q;
      int h;
      n = 1 << tl;
      q = 1 << (tl - 2);
      h = 1 << (tl - 1);
      if (i <= q) begin
         return quarter_cos(i, tl, fb);
      end else if (i <= h) begin
         return -quarter_cos(h - i, tl, fb);
      end else if (i <= h + q) begin
         return -quarter_cos(i - h, tl, fb);
      end else begin
         return quarter_cos(n - i, tl, fb);
      end
   endfunction

endpackage

`default_nettype wire

/* rtl/cnco_req_if.sv */
// Input channel: frequency or set-phase words.
`default_nettype none

interface cnco_req_if #(
   parameter int FRAC_BITS = cnco_pkg::FRAC_BITS_DEF
);
   logic                              valid;
   logic                              ready;
   logic                              action;
   logic signed [cnco_pkg::FREQ_W-1:0] frequency;
   logic [FRAC_BITS-1:0]              phase_value;

   modport source (output valid, output action, output frequency, output phase_value,
                   input ready);
   modport sink   (input valid, input action, input frequency, input phase_value,
                   output ready);
endinterface

`default_nettype wire

/* rtl/cnco_rsp_if.sv */
// Result channel: interpolated cosine samples.
`default_nettype none

interface cnco_rsp_if #(
   parameter int FRAC_BITS = cnco_pkg::FRAC_BITS_DEF
);
   logic                        valid;
   logic                        ready;
   logic signed [FRAC_BITS+1:0] sample;

   modport source (output valid, output sample, input ready);
   modport sink   (input valid, input sample, output ready);
endinterface

`default_nettype wire

/* rtl/cosine_nco_interpolated.sv */
// Cosine oscillator with phase accumulator, cosine ROM and linear interpolation.
// A frequency word is taken only in the idle state; its sample word passes the frequency
// multiply, the accumulate with table read, the two weight multiplies and the final sum, in
// turn, and no new word is taken until the sample word has left the summing step.
// A set-phase word loads the accumulator directly. A stalled output holds the summing step.
// Reset (synchronous): phase and increment register cleared, output empty; no clearing pass.
`default_nettype none

module cosine_nco_interpolated #(
   parameter int FRAC_BITS = cnco_pkg::FRAC_BITS_DEF,
   parameter int TABLE_LOG = cnco_pkg::TABLE_LOG_DEF
) (
   input  wire logic                        clock,
   input  wire logic                        reset,
   cnco_req_if.sink                         req_chan,
   cnco_rsp_if.source                       rsp_chan,
   input  wire logic                        csr_psel,
   input  wire logic                        csr_penable,
   input  wire logic                        csr_pwrite,
   input  wire logic [cnco_pkg::CSR_AW-1:0] csr_paddr,
   input  wire logic [cnco_pkg::CSR_W-1:0]  csr_pwdata,
   output logic      [cnco_pkg::CSR_W-1:0]  csr_prdata,
   output logic                             csr_pready
);

   localparam int SW       = FRAC_BITS + 2;
   localparam int TAB_N    = 1 << TABLE_LOG;
   localparam int LOW_BITS = FRAC_BITS - TABLE_LOG;
   localparam int FP_W     = FRAC_BITS + 1 + cnco_pkg::FREQ_W;
   localparam int IP_W     = SW + FRAC_BITS + 2;

   cnco_pkg::cnco_state_type state_ff, state_in;

   logic [FRAC_BITS-1:0]       inc_ff;
   logic [FRAC_BITS-1:0]       phase_ff;
   logic signed [FP_W-1:0]     fprod_ff;
   logic signed [SW-1:0]       rom_a_ff;
   logic signed [SW-1:0]       rom_b_ff;
   logic signed [IP_W-1:0]     prod_a_ff;
   logic signed [IP_W-1:0]     prod_b_ff;
   logic signed [SW-1:0]       sample_ff;
   logic                       rsp_valid_ff;

   logic signed [SW-1:0]       rom_tab [0:TAB_N];

   logic                       csr_wr;
   logic                       take;
   logic                       load_freq;
   logic                       load_phase;
   logic                       acc_en;
   logic                       lerp_en;
   logic                       out_free;
   logic                       out_load;
   logic [FRAC_BITS-1:0]       phase_in;
   logic [TABLE_LOG-1:0]       tab_idx;
   logic [TABLE_LOG:0]         idx_a;
   logic [TABLE_LOG:0]         idx_b;
   logic [FRAC_BITS-1:0]       frac;
   logic [FRAC_BITS:0]         one_minus;
   logic [SW-1:0]              sum_in;

   // Cosine table, fixed at elaboration
   for (genvar g = 0; g <= TAB_N; g++) begin : g_rom
      assign rom_tab[g] = SW'(cnco_pkg::cos_entry(g, TABLE_LOG, FRAC_BITS));
   end

   // Register port
   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite && csr_pready
                       && (csr_paddr[2] == 1'(cnco_pkg::REG_INCREMENT_PER_HZ));
   assign csr_prdata = (csr_paddr[2] == 1'(cnco_pkg::REG_INCREMENT_PER_HZ))
                       ? cnco_pkg::CSR_W'(inc_ff) : '0;

   always_ff @(posedge clock) begin
      if (reset) begin
         inc_ff <= '0;
      end else if (csr_wr) begin
         inc_ff <= csr_pwdata[FRAC_BITS-1:0];
      end
   end

   // Next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         cnco_pkg::ST_IDLE: begin
            if (req_chan.valid && (req_chan.action == cnco_pkg::ACT_FREQUENCY)) begin
               state_in = cnco_pkg::ST_ACC;
            end
         end
         cnco_pkg::ST_ACC:  state_in = cnco_pkg::ST_LERP;
         cnco_pkg::ST_LERP: state_in = cnco_pkg::ST_SUM;
         cnco_pkg::ST_SUM: begin
            if (out_free) begin
               state_in = cnco_pkg::ST_IDLE;
            end
         end
         default: state_in = cnco_pkg::ST_IDLE;
      endcase
   end

   // Control outputs
   always_comb begin
      req_chan.ready = (state_ff == cnco_pkg::ST_IDLE);
      take           = req_chan.valid && req_chan.ready;
      load_freq      = take && (req_chan.action == cnco_pkg::ACT_FREQUENCY);
      load_phase     = take && (req_chan.action == cnco_pkg::ACT_SET_PHASE);
      acc_en         = (state_ff == cnco_pkg::ST_ACC);
      lerp_en        = (state_ff == cnco_pkg::ST_LERP);
      out_load       = (state_ff == cnco_pkg::ST_SUM) && out_free;
   end

   assign out_free = !rsp_valid_ff || rsp_chan.ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= cnco_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // Phase step: increment per hertz times frequency
   always_ff @(posedge clock) begin
      if (load_freq) begin
         fprod_ff <= $signed({1'b0, inc_ff}) * req_chan.frequency;
      end
   end

   // Advance the accumulator; the floored step keeps only its low phase bits
   assign phase_in = phase_ff + fprod_ff[2*FRAC_BITS-1:FRAC_BITS];
   assign tab_idx  = phase_in[FRAC_BITS-1 -: TABLE_LOG];
   assign idx_a    = {1'b0, tab_idx};
   assign idx_b    = {1'b0, tab_idx} + (TABLE_LOG+1)'(1);

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= '0;
      end else if (load_phase) begin
         phase_ff <= req_chan.phase_value;
      end else if (acc_en) begin
         phase_ff <= phase_in;
      end
   end

   // Read the two neighbouring table entries
   always_ff @(posedge clock) begin
      if (acc_en) begin
         rom_a_ff <= rom_tab[idx_a];
         rom_b_ff <= rom_tab[idx_b];
      end
   end

   // Interpolation weights from the phase bits below the table index
   assign frac      = {phase_ff[LOW_BITS-1:0], {TABLE_LOG{1'b0}}};
   assign one_minus = (FRAC_BITS+1)'(1 << FRAC_BITS) - {1'b0, frac};

   // Both products are full width in the register's context
   always_ff @(posedge clock) begin
      if (lerp_en) begin
         prod_a_ff <= rom_a_ff * $signed({1'b0, one_minus});
         prod_b_ff <= rom_b_ff * $signed({2'b00, frac});
      end
   end

   // Floor each product and wrap the sum to the output width
   assign sum_in = prod_a_ff[FRAC_BITS +: SW] + prod_b_ff[FRAC_BITS +: SW];

   always_ff @(posedge clock) begin
      if (out_load) begin
         sample_ff <= $signed(sum_in);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (out_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_chan.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   assign rsp_chan.valid  = rsp_valid_ff;
   assign rsp_chan.sample = sample_ff;

   // A new sample word appears only out of the summing step
   a_rsp_from_sum: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == cnco_pkg::ST_SUM))
      else $error("sample word raised outside the summing step");

   // A set-phase word loads the accumulator directly
   a_phase_set: assert property (@(posedge clock) disable iff (reset)
      (take && (req_chan.action == cnco_pkg::ACT_SET_PHASE))
      |=> (phase_ff == $past(req_chan.phase_value)))
      else $error("accumulator did not take the set-phase value");

   // A frequency word always starts the accumulate step
   a_freq_start: assert property (@(posedge clock) disable iff (reset)
      load_freq |=> (state_ff == cnco_pkg::ST_ACC))
      else $error("frequency word did not start the accumulate step");

endmodule

`default_nettype wire
